@@ hw/rtl/five_ary_min_max_priority_queue_unit_defines.svh @@
// Assertion macros for the min/max priority queue unit.
// Used by the top level only; expands to nothing when SYNTHESIS is defined.
`ifndef FIVE_ARY_MIN_MAX_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define FIVE_ARY_MIN_MAX_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define FMMPQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("fmmpq assertion failed");
`define FMMPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fmmpq assertion failed");
`else
`define FMMPQ_ASSERT(label, prop)
`define FMMPQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hw/rtl/fmmpq_pkg.sv @@
// Types and codes shared by the priority queue cells and the top level.
// No dependencies.
package fmmpq_pkg;

  localparam int KEY_W    = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 10;

  typedef logic signed [KEY_W-1:0] key_t;

  // operation codes of an input item
  localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP_MIN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_MAX = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    key_t              key_value;
  } op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    key_t                removed_key;
    key_t                min_key;
    key_t                max_key;
    logic [COUNT_W-1:0]  held_count;
  } res_t;

  // command broadcast to every cell
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP_MIN,
    CMD_POP_MAX
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      launch;   // load the tail probe
  } cell_ctl_t;

  // token that carries the tail key toward the head cell
  typedef struct packed {
    logic vld;
    key_t key;
  } probe_t;

endpackage

@@ hw/rtl/fmmpq_cell.sv @@
// One slot of the sorted key chain, plus one stage of the tail probe line.
// Depends on fmmpq_pkg.
module fmmpq_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  fmmpq_pkg::cell_ctl_t ctl,
  input  fmmpq_pkg::key_t      ins_key,
  input  fmmpq_pkg::key_t      prev_key,
  input  logic                 prev_valid,
  input  logic                 prev_goes,
  input  fmmpq_pkg::key_t      next_key,
  input  logic                 next_valid,
  input  fmmpq_pkg::probe_t    next_probe,
  output fmmpq_pkg::key_t      key,
  output logic                 valid,
  output logic                 goes,
  output fmmpq_pkg::probe_t    probe
);

  // new key lands here or below: keys stay ascending, equal keys keep order
  assign goes = !valid || (ins_key < key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      probe.vld <= 1'b0;
    end else begin
      case (ctl.cmd)
        fmmpq_pkg::CMD_INSERT: begin
          if (prev_goes) begin
            valid <= prev_valid;
          end else if (goes) begin
            valid <= 1'b1;
          end
        end
        fmmpq_pkg::CMD_POP_MIN: valid <= next_valid;
        fmmpq_pkg::CMD_POP_MAX: valid <= valid && next_valid;  // drop the tail
        default: ;
      endcase
      if (ctl.launch) begin
        probe.vld <= valid && !next_valid;
      end else begin
        probe.vld <= next_probe.vld;
      end
    end
    case (ctl.cmd)
      fmmpq_pkg::CMD_INSERT: begin
        if (prev_goes) begin
          key <= prev_key;
        end else if (goes) begin
          key <= ins_key;
        end
      end
      fmmpq_pkg::CMD_POP_MIN: key <= next_key;
      default: ;
    endcase
    if (ctl.launch) begin
      probe.key <= key;
    end else begin
      probe.key <= next_probe.key;
    end
  end

endmodule

@@ hw/rtl/five_ary_min_max_priority_queue_unit.sv @@
// channel | handshake            | payload            | item
// op      | op_valid / op_ready   | fmmpq_pkg::op_t    | insert, pop min or pop max
// res     | res_valid / res_ready | fmmpq_pkg::res_t   | one result per op
//
// Keys sit ascending in a chain of CAPACITY cells; min is the head cell.
// Insert, pop min and refused ops: accepted, then the result register loads
// once it is free. Pop max with n keys held before it: the new tail key walks
// to the head through the probe line before the result register loads
// (no walk when n is 1).
// Reset clears every cell's valid bit. A waiting result does not
// stop the next op from being accepted; that op's result waits for the register.
// Depends on fmmpq_pkg, fmmpq_cell and the assertion macro header.
`include "five_ary_min_max_priority_queue_unit_defines.svh"

module five_ary_min_max_priority_queue_unit #(
  parameter int CAPACITY = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             op_valid,
  output logic             op_ready,
  input  fmmpq_pkg::op_t   op,
  output logic             res_valid,
  input  logic             res_ready,
  output fmmpq_pkg::res_t  res
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic                   launch;
  fmmpq_pkg::key_t        top_key;
  fmmpq_pkg::key_t        top_key_next;
  logic [fmmpq_pkg::STATUS_W-1:0] status_q;
  logic [fmmpq_pkg::STATUS_W-1:0] status_next;
  fmmpq_pkg::key_t        removed_q;
  fmmpq_pkg::key_t        removed_next;
  fmmpq_pkg::cell_cmd_t   cmd_dec;
  fmmpq_pkg::cell_ctl_t   ctl;
  logic                   scan_next;
  logic                   accept;
  logic                   full;
  logic                   empty;
  logic                   res_free;
  logic                   probe_hit;

  fmmpq_pkg::key_t        cell_key   [CAPACITY+1];
  logic                   cell_valid [CAPACITY+1];
  logic                   cell_goes  [CAPACITY+1];
  fmmpq_pkg::probe_t      cell_probe [CAPACITY+1];

  assign op_ready  = (state == ST_IDLE);
  assign accept    = op_valid && op_ready;
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign res_free  = !res_valid || res_ready;
  assign probe_hit = (state == ST_SCAN) && !launch && cell_probe[0].vld;

  always_comb begin
    cmd_dec      = fmmpq_pkg::CMD_HOLD;
    status_next  = fmmpq_pkg::STATUS_OK;
    removed_next = '0;
    count_next   = count;
    top_key_next = top_key;
    scan_next    = 1'b0;
    case (op.kind)
      fmmpq_pkg::KIND_INSERT: begin
        if (full) begin
          status_next = fmmpq_pkg::STATUS_FULL;
        end else begin
          cmd_dec    = fmmpq_pkg::CMD_INSERT;
          count_next = count + CNT_W'(1);
          if (empty || (top_key < op.key_value)) begin
            top_key_next = op.key_value;
          end
        end
      end
      fmmpq_pkg::KIND_POP_MIN: begin
        if (empty) begin
          status_next = fmmpq_pkg::STATUS_EMPTY;
        end else begin
          cmd_dec      = fmmpq_pkg::CMD_POP_MIN;
          removed_next = cell_key[0];
          count_next   = count - CNT_W'(1);
        end
      end
      fmmpq_pkg::KIND_POP_MAX: begin
        if (empty) begin
          status_next = fmmpq_pkg::STATUS_EMPTY;
        end else begin
          cmd_dec      = fmmpq_pkg::CMD_POP_MAX;
          removed_next = top_key;
          count_next   = count - CNT_W'(1);
          scan_next    = (count != CNT_W'(1));
        end
      end
      default: ;
    endcase
  end

  assign ctl.cmd    = accept ? cmd_dec : fmmpq_pkg::CMD_HOLD;
  assign ctl.launch = launch;

  // chain ends
  assign cell_goes[0]          = 1'b0;
  assign cell_key[CAPACITY]    = '0;
  assign cell_valid[CAPACITY]  = 1'b0;
  assign cell_probe[CAPACITY]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    fmmpq_pkg::key_t prev_key;
    logic            prev_valid;

    if (i == 0) begin : g_head
      assign prev_key   = '0;
      assign prev_valid = 1'b0;
    end else begin : g_body
      assign prev_key   = cell_key[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    fmmpq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .ins_key    (op.key_value),
      .prev_key   (prev_key),
      .prev_valid (prev_valid),
      .prev_goes  (cell_goes[i]),
      .next_key   (cell_key[i+1]),
      .next_valid (cell_valid[i+1]),
      .next_probe (cell_probe[i+1]),
      .key        (cell_key[i]),
      .valid      (cell_valid[i]),
      .goes       (cell_goes[i+1]),
      .probe      (cell_probe[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      launch    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      launch <= accept && scan_next;
      if ((state == ST_DONE) && res_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            count <= count_next;
            state <= scan_next ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          if (probe_hit) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_q  <= status_next;
      removed_q <= removed_next;
      top_key   <= top_key_next;
    end
    if (probe_hit) begin
      top_key <= cell_probe[0].key;
    end
    if ((state == ST_DONE) && res_free) begin
      res.status      <= status_q;
      res.removed_key <= removed_q;
      res.min_key     <= empty ? '0 : cell_key[0];
      res.max_key     <= empty ? '0 : top_key;
      res.held_count  <= fmmpq_pkg::COUNT_W'(count);
    end
  end

  `FMMPQ_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY))
  `FMMPQ_ASSERT(a_head_tracks_count, cell_valid[0] == (count != '0))
  `FMMPQ_ASSERT(a_probe_only_in_scan, !cell_probe[0].vld || (state == ST_SCAN))
  `FMMPQ_ASSERT_NEXT(a_insert_grows, ctl.cmd == fmmpq_pkg::CMD_INSERT, count == CNT_W'($past(count) + 1'b1))

endmodule
